@@ design/mexp_pkg.sv @@
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared widths, register codes, sequencer states and the multiplier
// status type for the modular exponentiation core.
// ----------------------------------------------------------------------------
package mexp_pkg;

	localparam int unsigned MEXP_DATA_W    = 63;
	localparam int unsigned MEXP_MODULUS_W = 63;
	localparam int unsigned MEXP_INDEX_W   = 8;

	typedef enum logic [MEXP_INDEX_W-1:0] {
		REG_MODULUS  = 8'd0,
		REG_EXPONENT = 8'd1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_NEXT,
		ST_MUL_ACC,
		ST_MUL_SQ,
		ST_FINISH
	} seq_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mul_sts_t;

endpackage

@@ design/mexp_if.sv @@
// ----------------------------------------------------------------------------
// mexp channel interfaces
// Valid/ready channels for configuration writes, incoming bases and
// outgoing results.
// ----------------------------------------------------------------------------
interface mexp_cfg_if import mexp_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [MEXP_INDEX_W-1:0] index;
	logic [MEXP_DATA_W-1:0]  data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

interface mexp_operand_if import mexp_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [MEXP_DATA_W-1:0] base;

	modport source(output valid, base, input ready);
	modport sink(input valid, base, output ready);
endinterface

interface mexp_result_if import mexp_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [MEXP_DATA_W-1:0] power;

	modport source(output valid, power, input ready);
	modport sink(input valid, power, output ready);
endinterface

@@ design/mexp_modmul.sv @@
// ----------------------------------------------------------------------------
// mexp_modmul
// Bit-serial modular multiplier: scans b from its top bit, one bit per
// cycle, keeping acc = (2*acc + bit*a) mod m below the modulus.
// ----------------------------------------------------------------------------
module mexp_modmul import mexp_pkg::*; #(
	parameter int unsigned W = MEXP_MODULUS_W
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic [W-1:0] m,
	output mul_sts_t     sts,
	output logic [W-1:0] product
);

	localparam int unsigned CNT_W = $clog2(W + 1);
	localparam int unsigned TW    = W + 3;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     acc_q;
	logic [W-1:0]     a_q;
	logic [W-1:0]     b_q;

	logic [TW-1:0] sum;
	logic [TW-1:0] less_one;
	logic [TW-1:0] less_two;
	logic [W-1:0]  acc_nxt;

	// sum < 3m, so subtracting 0, m or 2m lands exactly one candidate in [0, m)
	always_comb begin
		sum      = {2'b00, acc_q, 1'b0} + (b_q[W-1] ? {3'b000, a_q} : '0);
		less_one = sum - {3'b000, m};
		less_two = sum - {2'b00, m, 1'b0};
		if (!less_two[TW-1]) begin
			acc_nxt = less_two[W-1:0];
		end else if (!less_one[TW-1]) begin
			acc_nxt = less_one[W-1:0];
		end else begin
			acc_nxt = sum[W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
		end else if (busy_q) begin
			acc_q <= acc_nxt;
			b_q   <= {b_q[W-2:0], 1'b0};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign product  = acc_q;

	a_acc_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (acc_q < m))
		else $error("modmul accumulator left the residue range");

	a_modulus_held: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && $past(busy_q)) |-> $stable(m))
		else $error("modulus changed during a multiplication");

	a_done_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (!busy_q && $past(busy_q) && $past(cnt_q) == CNT_W'(1)))
		else $error("modmul done without a completed run");

endmodule

@@ design/mexp_seq.sv @@
// ----------------------------------------------------------------------------
// mexp_seq
// Right-to-left square-and-multiply sequencer: reduces the base, walks the
// exponent bit by bit through the shared multiplier, holds the result.
// ----------------------------------------------------------------------------
module mexp_seq import mexp_pkg::*; #(
	parameter int unsigned W = MEXP_MODULUS_W
) (
	input  logic                  clk,
	input  logic                  arst_n,
	mexp_operand_if.sink          operand,
	mexp_result_if.source         result,
	input  logic [W-1:0]          m,
	input  logic [W-1:0]          exponent,
	input  mul_sts_t              mul_sts,
	input  logic [W-1:0]          product,
	output logic                  mul_start,
	output logic [W-1:0]          mul_a,
	output logic [W-1:0]          mul_b
);

	seq_state_t state_q;
	seq_state_t state_d;

	logic [W-1:0]           e_q;
	logic [W-1:0]           acc_q;
	logic [W-1:0]           sq_q;
	logic                   out_valid_q;
	logic [MEXP_DATA_W-1:0] power_q;

	logic         slot_free;
	logic [W-1:0] acc_fold;

	assign slot_free = !out_valid_q || result.ready;
	// acc is below m except for its initial 1 when m is 1
	assign acc_fold  = (acc_q >= m) ? (acc_q - m) : acc_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (operand.valid) state_d = ST_REDUCE;
			end
			ST_REDUCE, ST_MUL_ACC, ST_MUL_SQ: begin
				if (mul_sts.done) state_d = ST_NEXT;
			end
			ST_NEXT: begin
				if (e_q == '0) begin
					state_d = ST_FINISH;
				end else if (e_q[0]) begin
					state_d = ST_MUL_ACC;
				end else begin
					state_d = ST_MUL_SQ;
				end
			end
			ST_FINISH: begin
				if (slot_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		operand.ready = 1'b0;
		mul_start     = 1'b0;
		mul_a         = sq_q;
		mul_b         = sq_q;
		unique case (state_q)
			ST_IDLE: begin
				operand.ready = 1'b1;
				mul_start     = operand.valid;
				mul_a         = W'(1);
				mul_b         = operand.base[W-1:0];
			end
			ST_NEXT: begin
				mul_start = (e_q != '0);
				if (e_q[0]) mul_a = acc_fold;
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_FINISH && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && operand.valid) begin
			e_q   <= exponent;
			acc_q <= W'(1);
		end
		if (mul_sts.done) begin
			case (state_q)
				ST_REDUCE: sq_q <= product;
				ST_MUL_ACC: begin
					acc_q <= product;
					e_q   <= {e_q[W-1:1], 1'b0};
				end
				ST_MUL_SQ: begin
					sq_q <= product;
					e_q  <= {1'b0, e_q[W-1:1]};
				end
				default: ;
			endcase
		end
		if (state_q == ST_FINISH && slot_free) begin
			power_q <= MEXP_DATA_W'(acc_q);
		end
	end

	assign result.valid = out_valid_q;
	assign result.power = power_q;

	a_acc_on_set_bit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL_ACC) |-> e_q[0])
		else $error("accumulate step without a set exponent bit");

	a_done_in_mul_state: assert property (@(posedge clk) disable iff (!arst_n)
		mul_sts.done |->
			(state_q == ST_REDUCE || state_q == ST_MUL_ACC || state_q == ST_MUL_SQ))
		else $error("multiplier finished outside a multiply state");

	a_idle_mul_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_FINISH || state_q == ST_NEXT)
			|-> !mul_sts.busy)
		else $error("multiplier busy while sequencer not waiting on it");

endmodule

@@ design/modular_exponentiation_core.sv @@
// ----------------------------------------------------------------------------
// modular_exponentiation_core
// power = base^exponent mod modulus by right-to-left square-and-multiply
// over a bit-serial modular multiplier.
// ----------------------------------------------------------------------------
//  channel   dir   payload               transfer when
//  cfg       in    index, data           valid & ready (ready always high)
//  operand   in    base                  valid & ready
//  result    out   power                 valid & ready
//
// A modular multiplication takes one bit of the multiplier operand per cycle
// (W = MODULUS_WIDTH bits). An item takes 1 + (L-1) + P multiplications,
// L the bit length and P the count of set bits of a nonzero exponent (one
// multiplication for a zero exponent).
// One item is in flight at a time; the result register frees the sequencer,
// so the next base is taken while a result waits on a stalled sink.
// Reset sets modulus to 1 and exponent to 0; no clearing pass is needed.
// ----------------------------------------------------------------------------
module modular_exponentiation_core import mexp_pkg::*; #(
	parameter int unsigned MODULUS_WIDTH = MEXP_MODULUS_W
) (
	input  logic           clk,
	input  logic           arst_n,
	mexp_cfg_if.sink       cfg,
	mexp_operand_if.sink   operand,
	mexp_result_if.source  result
);

	localparam int unsigned W = MODULUS_WIDTH;

	logic [W-1:0] modulus_q;
	logic [W-1:0] exponent_q;
	logic [W-1:0] m_eff;

	mul_sts_t     mul_sts;
	logic [W-1:0] product;
	logic         mul_start;
	logic [W-1:0] mul_a;
	logic [W-1:0] mul_b;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q  <= W'(1);
			exponent_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_MODULUS:  modulus_q  <= cfg.data[W-1:0];
				REG_EXPONENT: exponent_q <= cfg.data[W-1:0];
				default: ;
			endcase
		end
	end

	// zero modulus acts as modulus 1
	assign m_eff = (modulus_q == '0) ? W'(1) : modulus_q;

	mexp_seq #(.W(W)) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.operand   (operand),
		.result    (result),
		.m         (m_eff),
		.exponent  (exponent_q),
		.mul_sts   (mul_sts),
		.product   (product),
		.mul_start (mul_start),
		.mul_a     (mul_a),
		.mul_b     (mul_b)
	);

	mexp_modmul #(.W(W)) u_modmul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.m       (m_eff),
		.sts     (mul_sts),
		.product (product)
	);

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for modular_exponentiation_core. A plan of bases,
// register writes and drain points is built up front and played out by a
// clocked driver with random gaps. The monitor keeps its own copy of modulus
// and exponent, predicts base^exponent mod modulus for every accepted base,
// and checks each result transfer in order while stalling the result channel.
// ----------------------------------------------------------------------------
module testbench;
	import mexp_pkg::*;

	typedef logic [MEXP_DATA_W-1:0]  word_t;
	typedef logic [MEXP_INDEX_W-1:0] index_t;

	typedef enum logic [1:0] {
		STEP_BASE,
		STEP_WRITE,
		STEP_DRAIN
	} step_kind_t;

	typedef struct {
		step_kind_t kind;
		index_t     index;
		word_t      value;
	} step_t;

	localparam index_t      REG_UNMAPPED_TOP = '1;
	localparam int unsigned SETTLE_CYCLES    = 4;
	localparam int unsigned END_CYCLES       = 100;
	localparam int unsigned WATCHDOG_TIME    = 50_000_000;

	logic clk = 1'b0;
	logic arst_n;

	mexp_cfg_if     cfg_ch ();
	mexp_operand_if op_ch ();
	mexp_result_if  res_ch ();

	modular_exponentiation_core i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_ch),
		.operand (op_ch),
		.result  (res_ch)
	);

	step_t       plan_q[$];
	word_t       power_q[$];
	word_t       modulus_now;
	word_t       exponent_now;
	int unsigned mismatches = 0;
	int unsigned quiet_cycles;
	int unsigned src_gap;
	int unsigned snk_gap;
	bit          src_steady;
	bit          snk_steady;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Right-to-left square-and-multiply over full double-width products.
	function automatic word_t predict_power(word_t base, word_t modulus, word_t exponent);
		logic [127:0] m;
		logic [127:0] sq;
		logic [127:0] acc;
		word_t        e;
		if (exponent == '0)
			return word_t'(1);
		m = (modulus == '0) ? 128'd1 : 128'(modulus);
		sq = 128'(base) % m;
		acc = 128'd1 % m;
		e = exponent;
		while (e != '0) begin
			if (e[0])
				acc = (acc * sq) % m;
			e = e >> 1;
			sq = (sq * sq) % m;
		end
		return acc[MEXP_DATA_W-1:0];
	endfunction

	function automatic int unsigned draw_gap(bit steady);
		int unsigned roll;
		if (steady)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 4);
		return $urandom_range(16, 300);
	endfunction

	// Random value whose bit length is exactly bits.
	function automatic word_t rand_word(int unsigned bits);
		logic [63:0] raw;
		word_t       w;
		if (bits == 0)
			return '0;
		raw = {$urandom(), $urandom()};
		w = raw[MEXP_DATA_W-1:0] >> (MEXP_DATA_W - bits);
		w[bits-1] = 1'b1;
		return w;
	endfunction

	task automatic add_base(word_t b);
		step_t s;
		s.kind = STEP_BASE;
		s.index = '0;
		s.value = b;
		plan_q = {plan_q, s};
	endtask

	task automatic add_write(index_t idx, word_t v);
		step_t s;
		s.kind = STEP_WRITE;
		s.index = idx;
		s.value = v;
		plan_q = {plan_q, s};
	endtask

	task automatic add_drain();
		step_t s;
		s.kind = STEP_DRAIN;
		s.index = '0;
		s.value = '0;
		plan_q = {plan_q, s};
	endtask

	task automatic add_random_bases(word_t m, int unsigned count);
		word_t       b;
		word_t       m_eff;
		int unsigned i;
		m_eff = (m == '0) ? word_t'(1) : m;
		for (i = 0; i < count; i++) begin
			case ($urandom_range(0, 9))
				0: b = m - 1'b1;
				1: b = word_t'($urandom_range(0, 1));
				2, 3: b = rand_word(MEXP_DATA_W) % m_eff;
				default: b = rand_word($urandom_range(1, MEXP_DATA_W));
			endcase
			add_base(b);
			if ($urandom_range(0, 24) == 0)
				add_drain();
		end
	endtask

	// Driver: play the plan; register writes and drains wait for a quiet block.
	always @(posedge clk or negedge arst_n) begin : drive_proc
		logic op_v;
		logic cfg_v;
		logic taken;
		if (!arst_n) begin
			op_ch.valid <= 1'b0;
			op_ch.base <= '0;
			cfg_ch.valid <= 1'b0;
			cfg_ch.index <= '0;
			cfg_ch.data <= '0;
			src_gap <= 0;
			src_steady <= 1'b0;
		end else begin
			op_v = op_ch.valid && !op_ch.ready;
			cfg_v = cfg_ch.valid && !cfg_ch.ready;
			taken = 1'b0;
			if (!op_v && !cfg_v && plan_q.size() != 0) begin
				if (src_gap != 0) begin
					src_gap <= src_gap - 1;
				end else begin
					case (plan_q[0].kind)
						STEP_BASE: begin
							op_v = 1'b1;
							op_ch.base <= plan_q[0].value;
						end
						STEP_WRITE: begin
							if (quiet_cycles >= SETTLE_CYCLES && !op_ch.valid) begin
								cfg_v = 1'b1;
								cfg_ch.index <= plan_q[0].index;
								cfg_ch.data <= plan_q[0].value;
							end
						end
						default: begin
							taken = quiet_cycles != 0 && !op_ch.valid;
						end
					endcase
					if (op_v || cfg_v || taken) begin
						void'(plan_q.pop_front());
						src_gap <= draw_gap(src_steady);
						if ($urandom_range(0, 15) == 0)
							src_steady <= !src_steady;
					end
				end
			end
			op_ch.valid <= op_v;
			cfg_ch.valid <= cfg_v;
		end
	end

	// Monitor: track register writes, predict on each base transfer, check results.
	always @(posedge clk or negedge arst_n) begin : observe_proc
		word_t       want;
		int unsigned g;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			snk_gap <= 0;
			snk_steady <= 1'b0;
			quiet_cycles <= 0;
			modulus_now = word_t'(1);
			exponent_now = '0;
		end else begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.index)
					REG_MODULUS: modulus_now = cfg_ch.data;
					REG_EXPONENT: exponent_now = cfg_ch.data;
					default: ;
				endcase
			end
			if (op_ch.valid && op_ch.ready) begin
				want = predict_power(op_ch.base, modulus_now, exponent_now);
				power_q = {power_q, want};
			end
			g = snk_gap;
			if (res_ch.valid && res_ch.ready) begin
				if (power_q.size() == 0) begin
					mismatches++;
					$display("%0t: power %0d with nothing expected", $time, res_ch.power);
				end else begin
					want = power_q.pop_front();
					if (res_ch.power !== want) begin
						mismatches++;
						$display("%0t: power expected %0d, got %0d", $time, want, res_ch.power);
					end
				end
				g = draw_gap(snk_steady);
				if ($urandom_range(0, 7) == 0)
					snk_steady <= !snk_steady;
			end else if (g == 0 && !snk_steady && $urandom_range(0, 15) == 0) begin
				g = draw_gap(1'b0);
			end
			if (g != 0) begin
				res_ch.ready <= 1'b0;
				snk_gap <= g - 1;
			end else begin
				res_ch.ready <= 1'b1;
				snk_gap <= 0;
			end
			quiet_cycles <= (op_ch.valid || power_q.size() != 0) ? 0 : quiet_cycles + 1;
		end
	end

	initial begin : plan_proc
		word_t       m;
		word_t       e;
		int unsigned p;
		arst_n <= 1'b0;

		// reset settings: modulus one, exponent zero
		add_base('0);
		add_base('1);
		// zero modulus acts as one
		add_write(REG_MODULUS, '0);
		add_base(word_t'(5));
		add_write(REG_EXPONENT, word_t'(3));
		add_base('1);
		// writes to unmapped indexes must change nothing
		add_write(REG_UNMAPPED_TOP, '1);
		add_write(index_t'($urandom_range(2, 254)), rand_word(MEXP_DATA_W));
		add_base(word_t'(1));
		add_write(REG_MODULUS, word_t'(1));
		add_write(REG_EXPONENT, word_t'(5));
		add_base(word_t'(7));
		// largest modulus and exponent: base equal to modulus folds to zero
		add_write(REG_MODULUS, '1);
		add_write(REG_EXPONENT, '1);
		add_base(word_t'(2));
		add_base('1);
		add_base('1 - 1'b1);
		add_base('0);
		// large modulus, exponent one and two
		m = rand_word(MEXP_DATA_W);
		add_write(REG_MODULUS, m);
		add_write(REG_EXPONENT, word_t'(1));
		add_base(m);
		add_base(m + 1'b1);
		add_base(m - 1'b1);
		add_base('1);
		add_write(REG_EXPONENT, word_t'(2));
		add_base(m - 1'b1);
		add_base(rand_word(MEXP_DATA_W));
		add_drain();

		for (p = 0; p < 10; p++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: m = rand_word(MEXP_DATA_W);
				6, 7, 8: m = rand_word($urandom_range(2, 40));
				default: m = rand_word($urandom_range(1, 3));
			endcase
			if (p == 2 || p == 7)
				e = rand_word(MEXP_DATA_W);
			else if ($urandom_range(0, 9) == 0)
				e = '0;
			else
				e = rand_word($urandom_range(1, 14));
			if ($urandom_range(0, 1) == 0) begin
				add_write(REG_MODULUS, m);
				add_write(REG_EXPONENT, e);
			end else begin
				add_write(REG_EXPONENT, e);
				add_write(REG_MODULUS, m);
			end
			add_random_bases(m, 5);
			if (p == 4)
				add_drain();
			add_random_bases(m, 5);
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// let the last transfer reach the quiet count before waiting on it
		while (plan_q.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
		while (quiet_cycles < SETTLE_CYCLES)
			@(posedge clk);
		repeat (END_CYCLES) @(posedge clk);
		if (power_q.size() != 0)
			$display("%0t: power expected %0d, got nothing", $time, power_q[0]);
		if (mismatches == 0 && power_q.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin : watchdog_proc
		#(WATCHDOG_TIME);
		$display("end of test: mismatches");
		$finish;
	end

endmodule

@@ files.f @@
design/mexp_pkg.sv
design/mexp_if.sv
design/mexp_modmul.sv
design/mexp_seq.sv
design/modular_exponentiation_core.sv
tb/sv/testbench.sv
